>>> hdl/rsca_pkg.sv
// rsca_pkg: shared types and constants of the radius support counter
// no dependencies

package rsca_pkg;

  localparam int CFG_BITS  = 13;
  localparam int CNT_BITS  = 11;
  localparam int RAD_BITS  = 36;
  localparam int FAC_BITS  = 18;
  localparam int QUO_BITS  = 27;

  localparam logic [1:0] REG_DIMS         = 2'd0;
  localparam logic [1:0] REG_SOURCE_COUNT = 2'd1;
  localparam logic [1:0] REG_MIN_SUPPORTS = 2'd2;
  localparam logic [1:0] REG_MAX_SUPPORTS = 2'd3;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_GROW   = 2'd1;
  localparam logic [1:0] KIND_SHRINK = 2'd2;

  localparam logic [FAC_BITS-1:0] FAC_ONE_HALF = 18'd98304;
  localparam logic [FAC_BITS-1:0] FAC_033      = 18'd21627;
  localparam logic [FAC_BITS-1:0] FAC_MAX      = 18'd262143;
  localparam logic [RAD_BITS-1:0] RADIUS_MAX   = 36'hF_FFFF_FFFF;

  typedef struct packed {
    logic accept;
    logic scan;
    logic decide;
    logic div_step;
    logic mul;
    logic sum;
    logic out_load;
  } rsca_cmd_t;

  typedef struct packed {
    logic scan_idle;
    logic need_div;
    logic scale;
    logic div_done;
  } rsca_sts_t;

endpackage

>>> hdl/radius_support_count_adapt.sv
// radius_support_count_adapt: top level, controller plus datapath; uses rsca_pkg, rsca_ctrl, rsca_dp
// load item: idle goes straight to done and its result is loaded; query item: the scan reads n points,
// n = min(source_count, MAX_SOURCES), one store read per cycle, then the 27-step divider if needed
// throughput: one item in flight, the next item is taken only after the result of the last is registered
// synchronous reset sets control and config registers to their reset values; point store undefined until loaded

module radius_support_count_adapt #(
  parameter int MAX_SOURCES = 1024,
  parameter int COORD_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [9:0]                    source_index,
  input  logic signed [COORD_BITS-1:0]  coord_x,
  input  logic signed [COORD_BITS-1:0]  coord_y,
  input  logic signed [COORD_BITS-1:0]  coord_z,
  input  logic [rsca_pkg::RAD_BITS-1:0] query_r2,
  input  logic                          last_target,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rsca_pkg::CNT_BITS-1:0] support_count,
  output logic [rsca_pkg::RAD_BITS-1:0] new_radius_sq,
  output logic [1:0]                    adjust_kind,
  output logic                          saturated,
  output logic                          last_out,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [rsca_pkg::CFG_BITS-1:0] cfg_data
);

  rsca_pkg::rsca_cmd_t cmd;
  rsca_pkg::rsca_sts_t sts;

  rsca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rsca_dp #(.MAX_SOURCES(MAX_SOURCES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .source_index  (source_index),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .query_r2      (query_r2),
    .last_target   (last_target),
    .support_count (support_count),
    .new_radius_sq (new_radius_sq),
    .adjust_kind   (adjust_kind),
    .saturated     (saturated),
    .last_out      (last_out)
  );

endmodule

>>> hdl/rsca_ram.sv
// rsca_ram: generic single write, single read memory with registered read
// no dependencies

module rsca_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/rsca_dp.sv
// rsca_dp: datapath with config registers, point store, distance pipe,
// divider, scaling multiplier and output registers; uses rsca_pkg, rsca_ram

module rsca_dp #(
  parameter int MAX_SOURCES = 1024,
  parameter int COORD_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rsca_pkg::rsca_cmd_t           cmd,
  output rsca_pkg::rsca_sts_t           sts,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [rsca_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          req_type,
  input  logic [9:0]                    source_index,
  input  logic signed [COORD_BITS-1:0]  coord_x,
  input  logic signed [COORD_BITS-1:0]  coord_y,
  input  logic signed [COORD_BITS-1:0]  coord_z,
  input  logic [rsca_pkg::RAD_BITS-1:0] query_r2,
  input  logic                          last_target,
  output logic [rsca_pkg::CNT_BITS-1:0] support_count,
  output logic [rsca_pkg::RAD_BITS-1:0] new_radius_sq,
  output logic [1:0]                    adjust_kind,
  output logic                          saturated,
  output logic                          last_out
);

  localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int RD = 1 << AW;
  localparam int CB = COORD_BITS;
  localparam int AB = CB + 1;
  localparam int SB = 2 * AB;
  localparam int DB = (SB + 2 > rsca_pkg::RAD_BITS) ? SB + 2 : rsca_pkg::RAD_BITS;
  localparam int NB = rsca_pkg::CNT_BITS;
  localparam int QB = rsca_pkg::QUO_BITS;
  localparam int FB = rsca_pkg::FAC_BITS;
  localparam int RB = rsca_pkg::RAD_BITS;

  logic [1:0]    dims;
  logic [NB-1:0] source_count;
  logic [NB-1:0] min_supports;
  logic [12:0]   max_supports;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims         <= 2'd3;
      source_count <= '0;
      min_supports <= 11'd10;
      max_supports <= 13'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsca_pkg::REG_DIMS:         dims         <= cfg_data[1:0];
        rsca_pkg::REG_SOURCE_COUNT: source_count <= cfg_data[NB-1:0];
        rsca_pkg::REG_MIN_SUPPORTS: min_supports <= cfg_data[NB-1:0];
        rsca_pkg::REG_MAX_SUPPORTS: max_supports <= cfg_data[12:0];
      endcase
    end
  end

  // item registers
  logic                 req_q;
  logic                 last_q;
  logic signed [CB-1:0] tx, ty, tz;
  logic [RB-1:0]        r2_q;
  logic [NB-1:0]        n_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q  <= req_type;
      last_q <= last_target;
      tx     <= coord_x;
      ty     <= coord_y;
      tz     <= coord_z;
      r2_q   <= query_r2;
      if (32'(source_count) > MAX_SOURCES) begin
        n_q <= NB'(MAX_SOURCES);
      end else begin
        n_q <= source_count;
      end
    end
  end

  // point store
  logic            ram_we;
  logic [AW-1:0]   ram_raddr;
  logic [3*CB-1:0] ram_rdata;
  logic [NB-1:0]   s_q;

  assign ram_we    = cmd.accept && !req_type && (32'(source_index) < MAX_SOURCES);
  assign ram_raddr = AW'(s_q);

  rsca_ram #(.WIDTH(3 * CB), .DEPTH(RD)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(source_index)),
    .wdata ({coord_z, coord_y, coord_x}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // distance pipe: issue, read, square, compare
  logic          issue_v, sq_v;
  logic [SB-1:0] sqx, sqy, sqz;
  logic [NB-1:0] count;
  logic signed [AB-1:0] dx, dy, dz;
  logic [AB-1:0] ax, ay, az;
  logic [DB-1:0] sq_sum;

  assign dx = AB'(tx) - AB'($signed(ram_rdata[CB-1:0]));
  assign dy = AB'(ty) - AB'($signed(ram_rdata[2*CB-1:CB]));
  assign dz = AB'(tz) - AB'($signed(ram_rdata[3*CB-1:2*CB]));
  assign ax = dx[AB-1] ? AB'(-dx) : AB'(dx);
  assign ay = dy[AB-1] ? AB'(-dy) : AB'(dy);
  assign az = dz[AB-1] ? AB'(-dz) : AB'(dz);
  assign sq_sum = DB'(sqx) + DB'(sqy) + DB'(sqz);

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_v <= 1'b0;
      sq_v    <= 1'b0;
    end else begin
      issue_v <= cmd.scan && (s_q != n_q);
      sq_v    <= issue_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_q   <= '0;
      count <= '0;
    end else begin
      if (cmd.scan && (s_q != n_q)) begin
        s_q <= s_q + 1'b1;
      end
      if (sq_v && (sq_sum <= DB'(r2_q))) begin
        count <= count + 1'b1;
      end
    end
    sqx <= (dims > 2'd0) ? SB'(ax * ax) : '0;
    sqy <= (dims > 2'd1) ? SB'(ay * ay) : '0;
    sqz <= (dims > 2'd2) ? SB'(az * az) : '0;
  end

  // scaling decision
  logic          grow, shrink, grow_cap, shrink_cap;
  logic [FB-1:0] fac_q;
  logic          use_div;
  logic [1:0]    kind_q;

  assign grow       = count < min_supports;
  assign shrink     = !grow && (13'(count) > max_supports);
  assign grow_cap   = (count == '0) || (13'(min_supports) * 13'd2 > 13'(count) * 13'd3);
  assign shrink_cap = (15'(min_supports) * 15'd10) < 15'(count);

  // restoring divider, one quotient bit per cycle
  logic [QB-1:0] dvd, quo;
  logic [NB-1:0] rem;
  logic [NB:0]   rem_sh;
  logic [4:0]    div_cnt;

  assign rem_sh = {rem, dvd[QB-1]};

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      dvd     <= {min_supports, 16'd0};
      quo     <= '0;
      rem     <= '0;
      div_cnt <= 5'(QB);
    end else if (cmd.div_step && (div_cnt != 5'd0)) begin
      dvd     <= {dvd[QB-2:0], 1'b0};
      div_cnt <= div_cnt - 1'b1;
      if (rem_sh >= {1'b0, count}) begin
        rem <= NB'(rem_sh - {1'b0, count});
        quo <= {quo[QB-2:0], 1'b1};
      end else begin
        rem <= rem_sh[NB-1:0];
        quo <= {quo[QB-2:0], 1'b0};
      end
    end
  end

  // scaling multiply in two 18x18 halves, then sum and saturate
  logic [FB-1:0]   fac;
  logic [2*FB-1:0] p0, p1;
  logic [2*RB-FB-1:0] prod;
  logic [RB+1:0]   scaled;
  logic [RB-1:0]   res_r2;
  logic            res_sat;

  assign fac    = use_div ? ((|quo[QB-1:FB]) ? rsca_pkg::FAC_MAX : quo[FB-1:0]) : fac_q;
  assign prod   = {18'd0, p0} + {p1, 18'd0};
  assign scaled = prod[2*RB-FB-1:16];

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      use_div <= (grow && !grow_cap) || (shrink && !shrink_cap);
      fac_q   <= grow ? rsca_pkg::FAC_ONE_HALF : rsca_pkg::FAC_033;
      kind_q  <= grow ? rsca_pkg::KIND_GROW :
                 (shrink ? rsca_pkg::KIND_SHRINK : rsca_pkg::KIND_NONE);
      res_r2  <= r2_q;
      res_sat <= 1'b0;
    end
    if (cmd.mul) begin
      p0 <= r2_q[FB-1:0] * fac;
      p1 <= r2_q[RB-1:FB] * fac;
    end
    if (cmd.sum) begin
      if (|scaled[RB+1:RB]) begin
        res_r2  <= rsca_pkg::RADIUS_MAX;
        res_sat <= 1'b1;
      end else begin
        res_r2  <= scaled[RB-1:0];
        res_sat <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      support_count <= req_q ? count : '0;
      new_radius_sq <= req_q ? res_r2 : '0;
      adjust_kind   <= req_q ? kind_q : rsca_pkg::KIND_NONE;
      saturated     <= req_q && res_sat;
      last_out      <= req_q && last_q;
    end
  end

  always_comb begin
    sts.scan_idle = (s_q == n_q) && !issue_v && !sq_v;
    sts.need_div  = (grow && !grow_cap) || (shrink && !shrink_cap);
    sts.scale     = grow || shrink;
    sts.div_done  = (div_cnt == 5'd0);
  end

endmodule

>>> hdl/rsca_ctrl.sv
// rsca_ctrl: sequencer for load and query items and output handshake
// uses rsca_pkg

module rsca_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  output logic                out_valid,
  input  logic                out_stall,
  output rsca_pkg::rsca_cmd_t cmd,
  input  rsca_pkg::rsca_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_DIV, S_MUL, S_SUM, S_DONE
  } state_t;

  state_t state;
  logic   accept;
  logic   out_load;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    cmd.accept   = accept;
    cmd.scan     = (state == S_SCAN);
    cmd.decide   = (state == S_DECIDE);
    cmd.div_step = (state == S_DIV) && !sts.div_done;
    cmd.mul      = (state == S_MUL);
    cmd.sum      = (state == S_SUM);
    cmd.out_load = out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= req_type ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (sts.scan_idle) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          priority if (sts.need_div) begin
            state <= S_DIV;
          end else if (sts.scale) begin
            state <= S_MUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/rsca_chk.sv
// rsca_chk: port-level assertions for the radius support counter, with bind
// uses rsca_pkg; attaches to radius_support_count_adapt

module rsca_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rsca_pkg::CNT_BITS-1:0] support_count,
  input logic [rsca_pkg::RAD_BITS-1:0] new_radius_sq,
  input logic [1:0]                    adjust_kind,
  input logic                          saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(support_count) && $stable(new_radius_sq))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_sat_only_scaled: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> adjust_kind != rsca_pkg::KIND_NONE)
    else $error("saturation without scaling");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> new_radius_sq == rsca_pkg::RADIUS_MAX)
    else $error("saturated radius not at maximum");

endmodule

bind radius_support_count_adapt rsca_chk u_rsca_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .support_count (support_count),
  .new_radius_sq (new_radius_sq),
  .adjust_kind   (adjust_kind),
  .saturated     (saturated)
);

>>> bench/radius_support_count_adapt_tb.sv
// radius_support_count_adapt_tb: self-checking bench for the radius support counter
// loads source points, runs queries over several register settings, checks each result
// depends on rsca_pkg and radius_support_count_adapt

module radius_support_count_adapt_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [rsca_pkg::CNT_BITS-1:0] count;
    logic [rsca_pkg::RAD_BITS-1:0] radius;
    logic [1:0]                    kind;
    logic                          sat;
    logic                          last;
  } support_result_t;

  logic clk, rst;
  logic in_valid, in_stall, req_type, last_target;
  logic [9:0] source_index;
  logic signed [15:0] coord_x, coord_y, coord_z;
  logic [rsca_pkg::RAD_BITS-1:0] query_r2;
  logic out_valid, out_stall, saturated, last_out;
  logic [rsca_pkg::CNT_BITS-1:0] support_count;
  logic [rsca_pkg::RAD_BITS-1:0] new_radius_sq;
  logic [1:0] adjust_kind;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [rsca_pkg::CFG_BITS-1:0] cfg_data;

  logic signed [15:0] pt_x [1024];
  logic signed [15:0] pt_y [1024];
  logic signed [15:0] pt_z [1024];
  bit loaded [1024];
  logic [1:0]  m_dims;
  logic [10:0] m_source_count, m_min;
  logic [12:0] m_max;
  support_result_t pending_results[$];
  bit failed, quiet;

  radius_support_count_adapt dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("radius_support_count_adapt_tb: FAIL");
    $finish;
  end

  // output stall bursts
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  function automatic support_result_t predict_support(input logic rq, input logic [9:0] slot,
      input logic signed [15:0] x, y, z, input logic [rsca_pkg::RAD_BITS-1:0] r2,
      input logic lt);
    support_result_t res;
    longint unsigned n, cnt, sq_sum, fac, newr, mn, d;
    bit scale;
    res = '{default: '0};
    if (!rq) begin
      pt_x[slot] = x; pt_y[slot] = y; pt_z[slot] = z;
      loaded[slot] = 1;
      return res;
    end
    n = (m_source_count > 1024) ? 1024 : m_source_count;
    cnt = 0;
    for (int s = 0; s < n; s++) begin
      sq_sum = 0;
      if (m_dims >= 1) begin
        d = (x > pt_x[s]) ? x - pt_x[s] : pt_x[s] - x; sq_sum += d * d;
      end
      if (m_dims >= 2) begin
        d = (y > pt_y[s]) ? y - pt_y[s] : pt_y[s] - y; sq_sum += d * d;
      end
      if (m_dims >= 3) begin
        d = (z > pt_z[s]) ? z - pt_z[s] : pt_z[s] - z; sq_sum += d * d;
      end
      if (sq_sum <= r2) cnt++;
    end
    mn = m_min;
    newr = r2;
    scale = 0;
    fac = 0;
    res.kind = rsca_pkg::KIND_NONE;
    if (cnt < mn) begin
      res.kind = rsca_pkg::KIND_GROW;
      scale = 1;
      if (cnt == 0 || 2 * mn > 3 * cnt) fac = rsca_pkg::FAC_ONE_HALF;
      else fac = (mn << 16) / cnt;
    end else if (cnt > m_max) begin
      res.kind = rsca_pkg::KIND_SHRINK;
      scale = 1;
      if (10 * mn < cnt) fac = rsca_pkg::FAC_033;
      else begin
        fac = (mn << 16) / cnt;
        if (fac > rsca_pkg::FAC_MAX) fac = rsca_pkg::FAC_MAX;
      end
    end
    if (scale) begin
      newr = (longint'(r2) * fac) >> 16;
      if (newr > rsca_pkg::RADIUS_MAX) begin
        newr = rsca_pkg::RADIUS_MAX;
        res.sat = 1'b1;
      end
    end
    res.count = rsca_pkg::CNT_BITS'(cnt);
    res.radius = rsca_pkg::RAD_BITS'(newr);
    res.last = lt;
    return res;
  endfunction

  always @(posedge clk) begin
    support_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result count %0d", $time, support_count);
        failed = 1;
      end else begin
        e = pending_results.pop_front();
        if (support_count !== e.count) begin
          $display("%0t support_count exp %0d got %0d", $time, e.count, support_count);
          failed = 1;
        end
        if (new_radius_sq !== e.radius) begin
          $display("%0t new_radius_sq exp %0d got %0d", $time, e.radius, new_radius_sq);
          failed = 1;
        end
        if (adjust_kind !== e.kind) begin
          $display("%0t adjust_kind exp %0d got %0d", $time, e.kind, adjust_kind);
          failed = 1;
        end
        if (saturated !== e.sat) begin
          $display("%0t saturated exp %0d got %0d", $time, e.sat, saturated);
          failed = 1;
        end
        if (last_out !== e.last) begin
          $display("%0t last_out exp %0d got %0d", $time, e.last, last_out);
          failed = 1;
        end
      end
    end
  end

  task automatic send_item(input logic rq, input logic [9:0] slot,
      input logic signed [15:0] x, y, z, input logic [rsca_pkg::RAD_BITS-1:0] r2,
      input logic lt);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req_type <= rq; source_index <= slot; coord_x <= x; coord_y <= y; coord_z <= z;
    query_r2 <= r2; last_target <= lt; in_valid <= 1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_results.push_back(predict_support(rq, slot, x, y, z, r2, lt));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [rsca_pkg::CFG_BITS-1:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      rsca_pkg::REG_DIMS:         m_dims = val[1:0];
      rsca_pkg::REG_SOURCE_COUNT: m_source_count = val[10:0];
      rsca_pkg::REG_MIN_SUPPORTS: m_min = val[10:0];
      rsca_pkg::REG_MAX_SUPPORTS: m_max = val[12:0];
    endcase
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic set_regs(input int d, sc, mn, mx);
    drain();
    write_reg(rsca_pkg::REG_DIMS, rsca_pkg::CFG_BITS'(d));
    write_reg(rsca_pkg::REG_SOURCE_COUNT, rsca_pkg::CFG_BITS'(sc));
    write_reg(rsca_pkg::REG_MIN_SUPPORTS, rsca_pkg::CFG_BITS'(mn));
    write_reg(rsca_pkg::REG_MAX_SUPPORTS, rsca_pkg::CFG_BITS'(mx));
  endtask

  function automatic logic signed [15:0] near_coord();
    return $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 900)) - 450);
  endfunction

  function automatic logic [rsca_pkg::RAD_BITS-1:0] rand_radius();
    case ($urandom_range(0, 5))
      0:       return rsca_pkg::RAD_BITS'({$urandom, $urandom});
      1:       return rsca_pkg::RAD_BITS'($urandom_range(0, 40000));
      default: return rsca_pkg::RAD_BITS'($urandom_range(0, 700000));
    endcase
  endfunction

  task automatic send_load(input int slot);
    send_item(1'b0, 10'(slot), near_coord(), near_coord(), near_coord(), rand_radius(),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_query(input logic [rsca_pkg::RAD_BITS-1:0] r2);
    send_item(1'b1, 10'($urandom), near_coord(), near_coord(), near_coord(), r2,
              1'($urandom_range(0, 1)));
  endtask

  task automatic test_grid_load;
    for (int s = 0; s < 64; s++)
      send_item(1'b0, 10'(s), 16'((s % 8) * 100 - 350), 16'(((s / 8) % 8) * 100 - 350),
                16'($urandom_range(0, 200)), '0, 1'b0);
  endtask

  task automatic test_directed;
    set_regs(3, 64, 10, 30);
    send_item(1, 0, -16'sd32768, -16'sd32768, -16'sd32768, rsca_pkg::RADIUS_MAX, 1);
    send_item(1, 10'h3FF, 16'sd32767, 16'sd32767, 16'sd32767, 0, 0);
    send_item(1, 0, 0, 0, 100, 0, 1);
    send_item(1, 0, 0, 0, 100, 200000, 0);
    send_item(1, 0, 0, 0, 100, 2000000, 1);
    send_item(0, 10'h3FF, -16'sd32768, 16'sd32767, 0, rsca_pkg::RADIUS_MAX, 1);
    set_regs(0, 64, 10, 30);
    send_item(1, 0, 16'sd32767, -16'sd32768, 0, 0, 1);
    set_regs(2, 64, 0, 30);
    send_item(1, 0, 0, 0, 0, 0, 0);
    send_item(1, 0, 0, 0, 0, 50000, 0);
    send_item(1, 0, 0, 0, 0, rsca_pkg::RADIUS_MAX, 1);
    set_regs(1, 64, 1024, 1);
    send_item(1, 0, 0, 0, 0, rsca_pkg::RADIUS_MAX, 0);
    send_item(1, 0, 0, 0, 0, 30000, 1);
    set_regs(3, 0, 1, 4096);
    send_item(1, 0, 0, 0, 0, rsca_pkg::RADIUS_MAX, 0);
    set_regs(3, 64, 3, 8191);
    send_item(1, 0, 0, 0, 0, 200000, 0);
    set_regs(3, 64, 2047, 0);
    send_item(1, 0, 0, 0, 0, 40000, 1);
  endtask

  task automatic test_more_sources;
    quiet = 1;
    for (int s = 64; s < 128; s++) send_load(s);
    quiet = 0;
    set_regs(3, 128, 100, 300);
    repeat (4) send_query(rand_radius());
    set_regs(2, 128, 5, 15);
    repeat (4) send_query(rand_radius());
  endtask

  task automatic test_random;
    int lim;
    for (int ph = 0; ph < 8; ph++) begin
      lim = 1;
      while (lim < 1024 && loaded[lim]) lim++;
      set_regs($urandom_range(0, 3), $urandom_range(0, lim < 128 ? lim : 128),
               $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 30),
               $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 90));
      if (ph == 7) quiet = 1;
      for (int i = 0; i < 48; i++) begin
        if ($urandom_range(0, 3) == 0) send_load($urandom_range(0, 1023));
        else send_query(rand_radius());
        if (ph == 3 && i == 24) drain();
      end
    end
  endtask

  initial begin
    rst = 1; in_valid = 0; req_type = 0; source_index = 0; coord_x = 0; coord_y = 0;
    coord_z = 0; query_r2 = 0; last_target = 0; cfg_we = 0; cfg_index = rsca_pkg::REG_DIMS;
    cfg_data = 0; failed = 0; quiet = 0;
    m_dims = 3; m_source_count = 0; m_min = 10; m_max = 30;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_grid_load();
    test_directed();
    test_more_sources();
    test_random();
    drain();
    repeat (1200) @(negedge clk);
    if (!failed && pending_results.size() == 0)
      $display("radius_support_count_adapt_tb: PASS");
    else
      $display("radius_support_count_adapt_tb: FAIL");
    $finish;
  end

endmodule
